### hw/rtl/xfsd_pkg.sv
// ---------------------------------------------------------------------------
// xfsd_pkg
// Shared constants, codes and types of the XOR float stream decoder.
// ---------------------------------------------------------------------------
package xfsd_pkg;

    localparam int WORD_W      = 64;
    localparam int BUF_W       = 192;
    localparam int BB_W        = 8;
    localparam int COUNT_W     = 24;
    localparam int MAX_RESULTS = 16;
    localparam int N_W         = 5;
    localparam logic [COUNT_W-1:0] VALUE_COUNT_RESET = 24'd1024;

    localparam logic [1:0] FLAG_COPY        = 2'd0;
    localparam logic [1:0] FLAG_REF_XOR     = 2'd1;
    localparam logic [1:0] FLAG_PREV        = 2'd2;
    localparam logic [1:0] FLAG_PREV_NEW_LZ = 2'd3;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } hist_ctl_t;

    function automatic logic [4:0] lz_decode(input logic [2:0] code);
        logic [4:0] lz;
        case (code)
            3'd0:    lz = 5'd0;
            3'd1:    lz = 5'd8;
            3'd2:    lz = 5'd12;
            3'd3:    lz = 5'd16;
            3'd4:    lz = 5'd18;
            3'd5:    lz = 5'd20;
            3'd6:    lz = 5'd22;
            default: lz = 5'd24;
        endcase
        return lz;
    endfunction

endpackage

### hw/rtl/xfsd_if.sv
// ---------------------------------------------------------------------------
// xfsd_if
// Valid/ready channels for compressed words and decoded values.
// ---------------------------------------------------------------------------
interface xfsd_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] stream_word;
    logic        start_req;

    modport source (output valid, output stream_word, output start_req, input ready);
    modport sink (input valid, input stream_word, input start_req, output ready);
endinterface

interface xfsd_value_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        last;
    logic        block_done;

    modport source (output valid, output value, output last, output block_done, input ready);
    modport sink (input valid, input value, input last, input block_done, output ready);
endinterface

### hw/rtl/xfsd_hist_mem.sv
// ---------------------------------------------------------------------------
// xfsd_hist_mem
// History ring of decoded values: one write, one registered read, valid bits.
// ---------------------------------------------------------------------------
module xfsd_hist_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  xfsd_pkg::hist_ctl_t ctl,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    input  logic [63:0]         wr_data,
    output logic [63:0]         rd_data
);

    logic [63:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [63:0]    rd_data_reg;
    logic           rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 64'd0;

endmodule

### hw/rtl/xor_float_stream_decoder_top.sv
// ---------------------------------------------------------------------------
// xor_float_stream_decoder_top
// Chimp128-style decoder: compressed 64-bit words in, double bit patterns out.
// ---------------------------------------------------------------------------
// One code is decoded per cycle when it refers to the previous value and no
// result waiting at the output holds the decoder; a code that reads the
// history ring takes a further S_HIST step, as its synchronous RAM port
// returns the entry registered. A word is loaded in S_IDLE, yields at most
// 16 values and is closed in S_DECODE when decoding stops. Each value is held
// back until the next is decoded or the word closes, so the decoder knows
// whether it is the last of its word. start_req clears all state at once; the
// history ring resets through valid bits and needs no clearing pass.
module xor_float_stream_decoder_top #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [23:0]         cfg_wr_data,
    xfsd_word_if.sink           stream,
    xfsd_value_if.source        result
);

    localparam int IDX_W  = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SEG_HI = xfsd_pkg::BUF_W - 1 - (11 + IDX_W);
    localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] WPTR_MAX = IDX_W'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_HIST} state_t;

    state_t                          state_reg;
    logic [xfsd_pkg::COUNT_W-1:0]    vc_reg;
    logic [xfsd_pkg::COUNT_W-1:0]    cnt_reg;
    logic [xfsd_pkg::BUF_W-1:0]      buf_reg;
    logic [xfsd_pkg::BB_W-1:0]       bb_reg;
    logic                            first_reg;
    logic [4:0]                      lz_reg;
    logic [63:0]                     prev_reg;
    logic [IDX_W-1:0]                wptr_reg;
    logic [xfsd_pkg::N_W-1:0]        n_reg;
    logic [63:0]                     delta_reg;
    logic                            pend_valid_reg;
    logic [63:0]                     pend_value_reg;
    logic                            pend_done_reg;
    logic                            out_valid_reg;
    logic [63:0]                     out_value_reg;
    logic                            out_last_reg;
    logic                            out_done_reg;

    logic                            accept;
    logic                            out_free;
    logic                            out_load;
    logic                            append;
    logic [1:0]                      flag;
    logic [4:0]                      lz_new3;
    logic [4:0]                      lz_new1;
    logic [IDX_W-1:0]                idx_raw;
    logic [IDX_W-1:0]                idx_mod;
    logic [5:0]                      sig6;
    logic [6:0]                      sig;
    logic [7:0]                      tz_sum;
    logic [6:0]                      tz;
    logic [63:0]                     seg1;
    logic [63:0]                     delta1;
    logic [63:0]                     delta2;
    logic [63:0]                     delta3;
    logic [7:0]                      need;
    logic                            can;
    logic                            uses_hist;
    logic                            stop;
    logic [63:0]                     direct_v;
    logic [63:0]                     commit_v;
    logic                            commit;
    logic [xfsd_pkg::COUNT_W-1:0]    cnt_inc;
    logic                            done_now;
    logic [xfsd_pkg::BUF_W-1:0]      buf_consumed;
    logic [xfsd_pkg::COUNT_W-1:0]    cnt_eff;
    logic [xfsd_pkg::BUF_W-1:0]      buf_eff;
    logic [xfsd_pkg::BB_W-1:0]       bb_eff;
    logic [xfsd_pkg::BUF_W-1:0]      buf_next;
    logic [63:0]                     hist_rd;
    xfsd_pkg::hist_ctl_t             hist_ctl;

    assign accept   = stream.valid && stream.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign flag    = buf_reg[191:190];
    assign lz_new3 = xfsd_pkg::lz_decode(buf_reg[189:187]);
    assign idx_raw = buf_reg[189 -: IDX_W];
    assign lz_new1 = xfsd_pkg::lz_decode(buf_reg[189-IDX_W -: 3]);
    assign sig6    = buf_reg[186-IDX_W -: 6];
    assign sig     = (sig6 == 6'd0) ? 7'd64 : {1'b0, sig6};
    assign tz_sum  = {1'b0, sig} + {3'b000, lz_new1};
    assign tz      = (tz_sum >= 8'd64) ? 7'd0 : 7'(8'd64 - tz_sum);
    assign seg1    = buf_reg[SEG_HI -: 64];
    assign delta1  = (seg1 >> (7'd64 - sig)) << tz;
    assign delta2  = buf_reg[189:126] >> lz_reg;
    assign delta3  = buf_reg[186:123] >> lz_new3;
    assign idx_mod = ({1'b0, idx_raw} >= DEPTH_V) ?
                     IDX_W'({1'b0, idx_raw} - DEPTH_V) : idx_raw;

    always_comb
    begin
        need      = 8'd64;
        uses_hist = 1'b0;
        direct_v  = buf_reg[191:128];
        if (!first_reg)
        begin
            case (flag)
                xfsd_pkg::FLAG_PREV_NEW_LZ:
                begin
                    need     = 8'd69 - {3'b000, lz_new3};
                    direct_v = prev_reg ^ delta3;
                end
                xfsd_pkg::FLAG_PREV:
                begin
                    need     = 8'd66 - {3'b000, lz_reg};
                    direct_v = prev_reg ^ delta2;
                end
                xfsd_pkg::FLAG_REF_XOR:
                begin
                    need      = 8'(11 + IDX_W) + {1'b0, sig};
                    uses_hist = 1'b1;
                end
                default:
                begin
                    need      = 8'(2 + IDX_W);
                    uses_hist = 1'b1;
                end
            endcase
        end
    end

    assign can          = bb_reg >= need;
    assign stop         = (n_reg == xfsd_pkg::N_W'(xfsd_pkg::MAX_RESULTS)) ||
                          (cnt_reg >= vc_reg) || !can;
    assign buf_consumed = buf_reg << need;
    assign commit       = ((state_reg == S_DECODE) && out_free && !stop && !uses_hist) ||
                          ((state_reg == S_HIST) && out_free);
    assign commit_v     = (state_reg == S_HIST) ? (hist_rd ^ delta_reg) : direct_v;
    assign cnt_inc      = cnt_reg + 24'd1;
    assign done_now     = cnt_inc >= vc_reg;
    assign out_load     = pend_valid_reg &&
                          (commit || ((state_reg == S_DECODE) && out_free && stop));

    assign cnt_eff  = stream.start_req ? '0 : cnt_reg;
    assign buf_eff  = stream.start_req ? '0 : buf_reg;
    assign bb_eff   = stream.start_req ? '0 : bb_reg;
    assign buf_next = buf_eff | ({stream.stream_word, 128'd0} >> bb_eff);
    assign append   = (cnt_eff < vc_reg) && (bb_eff <= 8'd128);

    assign hist_ctl.clear = accept && stream.start_req;
    assign hist_ctl.rd_en = (state_reg == S_DECODE) && out_free && !stop && uses_hist;
    assign hist_ctl.wr_en = commit;

    xfsd_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (IDX_W)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (hist_ctl),
        .rd_addr (idx_mod),
        .wr_addr (wptr_reg),
        .wr_data (commit_v),
        .rd_data (hist_rd)
    );

    always_ff @(posedge clk)
    begin
        if (hist_ctl.rd_en)
        begin
            delta_reg <= (flag == xfsd_pkg::FLAG_REF_XOR) ? delta1 : 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vc_reg         <= xfsd_pkg::VALUE_COUNT_RESET;
            cnt_reg        <= '0;
            buf_reg        <= '0;
            bb_reg         <= '0;
            first_reg      <= 1'b1;
            lz_reg         <= '0;
            prev_reg       <= '0;
            wptr_reg       <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_value_reg <= '0;
            pend_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vc_reg <= cfg_wr_data;
            end
            if (result.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (stream.start_req)
                        begin
                            cnt_reg   <= '0;
                            first_reg <= 1'b1;
                            lz_reg    <= '0;
                            prev_reg  <= '0;
                            wptr_reg  <= '0;
                        end
                        buf_reg <= append ? buf_next : buf_eff;
                        bb_reg  <= append ? (bb_eff + 8'd64) : bb_eff;
                        if (cnt_eff < vc_reg)
                        begin
                            n_reg     <= '0;
                            state_reg <= S_DECODE;
                        end
                    end
                end
                S_DECODE:
                begin
                    if (out_free)
                    begin
                        if (stop)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_value_reg  <= pend_value_reg;
                                out_last_reg   <= 1'b1;
                                out_done_reg   <= pend_done_reg;
                                pend_valid_reg <= 1'b0;
                            end
                            state_reg <= S_IDLE;
                        end
                        else if (uses_hist)
                        begin
                            if (flag == xfsd_pkg::FLAG_REF_XOR)
                            begin
                                lz_reg <= lz_new1;
                            end
                            buf_reg   <= buf_consumed;
                            bb_reg    <= bb_reg - need;
                            state_reg <= S_HIST;
                        end
                        else
                        begin
                            if (!first_reg && flag == xfsd_pkg::FLAG_PREV_NEW_LZ)
                            begin
                                lz_reg <= lz_new3;
                            end
                            first_reg <= 1'b0;
                            if (done_now)
                            begin
                                buf_reg <= '0;
                                bb_reg  <= '0;
                            end
                            else
                            begin
                                buf_reg <= buf_consumed;
                                bb_reg  <= bb_reg - need;
                            end
                        end
                    end
                end
                S_HIST:
                begin
                    if (out_free)
                    begin
                        if (done_now)
                        begin
                            buf_reg <= '0;
                            bb_reg  <= '0;
                        end
                        state_reg <= S_DECODE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (commit)
            begin
                prev_reg       <= commit_v;
                cnt_reg        <= cnt_inc;
                wptr_reg       <= ((wptr_reg == WPTR_MAX) || (cnt_inc == '0)) ?
                                  '0 : wptr_reg + 1'b1;
                n_reg          <= n_reg + 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_value_reg <= pend_value_reg;
                    out_last_reg  <= 1'b0;
                    out_done_reg  <= pend_done_reg;
                end
                pend_valid_reg <= 1'b1;
                pend_value_reg <= commit_v;
                pend_done_reg  <= done_now;
            end
        end
    end

    assign stream.ready      = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.value      = out_value_reg;
    assign result.last       = out_last_reg;
    assign result.block_done = out_done_reg;

    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        stream.ready |-> !pend_valid_reg)
        else $error("input taken while a decoded value is still held back");

    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(hist_ctl.rd_en && hist_ctl.wr_en))
        else $error("history read and write in the same cycle");

    a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bb_reg <= 8'd192)
        else $error("bit buffer overfilled");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.block_done) |-> result.last)
        else $error("block end not marked as final transfer of its word");

    a_hist_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HIST && out_free) |=> (state_reg == S_DECODE))
        else $error("history step did not return to decode");

endmodule

### tb/sv/tb_xor_float_stream_decoder_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_xor_float_stream_decoder_top
// Builds compressed blocks with every code flag and random content, feeds them
// as 64-bit words under varying source gaps and sink stalls, and compares each
// decoded value against a cycle-free software decoder of the same stream.
// ---------------------------------------------------------------------------
module tb_xor_float_stream_decoder_top;

    typedef struct {
        logic [63:0] value;
        logic        last;
        logic        block_done;
    } dec_value_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [23:0] cfg_wr_data;

    xfsd_word_if  stream ();
    xfsd_value_if result ();

    xor_float_stream_decoder_top u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .stream(stream.sink),
        .result(result.source)
    );

    dec_value_t  value_q[$];
    logic [63:0] hist_m[128];
    logic [63:0] prev_m;
    logic [4:0]  lz_m;
    logic [23:0] count_m;
    logic [191:0] buf_m;
    int unsigned nbits_m;
    logic        first_m;
    logic [23:0] vcount_m;
    int unsigned src_idle;
    int unsigned snk_stall;
    int unsigned words_sent;
    int unsigned values_seen;
    int unsigned errors;
    int unsigned enc_lz;
    bit          code_bits[$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [4:0] lz_code_m(input logic [2:0] c);
        case (c)
            3'd0: return 5'd0;
            3'd1: return 5'd8;
            3'd2: return 5'd12;
            3'd3: return 5'd16;
            3'd4: return 5'd18;
            3'd5: return 5'd20;
            3'd6: return 5'd22;
            default: return 5'd24;
        endcase
    endfunction

    function automatic logic [63:0] peek_m(input int unsigned off, input int unsigned n);
        logic [191:0] t;
        t = buf_m << off;
        return t[191 -: 64] >> (64 - n);
    endfunction

    function automatic void consume_m(input int unsigned n);
        buf_m = buf_m << n;
        nbits_m = (n >= nbits_m) ? 0 : nbits_m - n;
    endfunction

    function automatic void clear_m();
        foreach (hist_m[k])
            hist_m[k] = '0;
        prev_m = '0;
        lz_m = '0;
        count_m = '0;
        buf_m = '0;
        nbits_m = 0;
        first_m = 1'b1;
    endfunction

    function automatic bit decode_one(output logic [63:0] v);
        int unsigned lz;
        int unsigned need;
        int unsigned sig;
        int unsigned tz;
        logic [1:0] flag;
        logic [6:0] idx;
        lz = (lz_m > 24) ? 24 : lz_m;
        if (first_m)
        begin
            if (nbits_m < 64)
                return 0;
            v = peek_m(0, 64);
            consume_m(64);
            first_m = 1'b0;
        end
        else
        begin
            if (nbits_m < 2)
                return 0;
            flag = 2'(peek_m(0, 2));
            if (flag == xfsd_pkg::FLAG_PREV_NEW_LZ)
            begin
                if (nbits_m < 5)
                    return 0;
                lz = 32'(lz_code_m(3'(peek_m(2, 3))));
                need = 5 + 64 - lz;
                if (nbits_m < need)
                    return 0;
                v = prev_m ^ peek_m(5, 64 - lz);
                lz_m = 5'(lz);
                consume_m(need);
            end
            else if (flag == xfsd_pkg::FLAG_PREV)
            begin
                need = 2 + 64 - lz;
                if (nbits_m < need)
                    return 0;
                v = prev_m ^ peek_m(2, 64 - lz);
                consume_m(need);
            end
            else if (flag == xfsd_pkg::FLAG_REF_XOR)
            begin
                need = 18;
                if (nbits_m < need)
                    return 0;
                idx = 7'(peek_m(2, 7));
                lz = 32'(lz_code_m(3'(peek_m(9, 3))));
                sig = 32'(peek_m(12, 6));
                if (sig == 0)
                    sig = 64;
                if (nbits_m < need + sig)
                    return 0;
                tz = (sig + lz >= 64) ? 0 : 64 - sig - lz;
                v = hist_m[idx] ^ (peek_m(need, sig) << tz);
                lz_m = 5'(lz);
                consume_m(need + sig);
            end
            else
            begin
                if (nbits_m < 9)
                    return 0;
                idx = 7'(peek_m(2, 7));
                v = hist_m[idx];
                consume_m(9);
            end
        end
        hist_m[count_m[6:0]] = v;
        prev_m = v;
        count_m = count_m + 1'b1;
        return 1;
    endfunction

    function automatic void predict_word(input logic [63:0] w, input logic s);
        dec_value_t out_q[$];
        dec_value_t r;
        logic [63:0] v;
        if (s)
            clear_m();
        if (count_m >= vcount_m)
            return;
        if (nbits_m <= 128)
        begin
            buf_m = buf_m | ({w, 128'b0} >> nbits_m);
            nbits_m = nbits_m + 64;
        end
        while (out_q.size() < xfsd_pkg::MAX_RESULTS && count_m < vcount_m && decode_one(v))
        begin
            r.value = v;
            r.last = 1'b0;
            r.block_done = 1'b0;
            if (count_m >= vcount_m)
            begin
                r.block_done = 1'b1;
                buf_m = '0;
                nbits_m = 0;
            end
            out_q.push_back(r);
        end
        if (out_q.size() > 0)
            out_q[out_q.size() - 1].last = 1'b1;
        foreach (out_q[k])
            value_q.push_back(out_q[k]);
    endfunction

    initial
    begin
        dec_value_t e;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result.ready = ($urandom_range(99) >= snk_stall);
            @(posedge clk);
            if (rst_n && result.valid && result.ready)
            begin
                values_seen++;
                if (value_q.size() == 0)
                begin
                    $error("value: unexpected transfer %h", result.value);
                    errors++;
                end
                else
                begin
                    e = value_q.pop_front();
                    if (result.value !== e.value)
                    begin
                        $error("value: expected %h actual %h", e.value, result.value);
                        errors++;
                    end
                    if (result.last !== e.last)
                    begin
                        $error("last: expected %b actual %b", e.last, result.last);
                        errors++;
                    end
                    if (result.block_done !== e.block_done)
                    begin
                        $error("block_done: expected %b actual %b", e.block_done,
                               result.block_done);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_word(input logic [63:0] w, input logic s);
        while ($urandom_range(99) < src_idle)
        begin
            stream.valid = 1'b0;
            @(negedge clk);
        end
        stream.valid = 1'b1;
        stream.stream_word = w;
        stream.start_req = s;
        do
            @(posedge clk);
        while (!stream.ready);
        predict_word(w, s);
        words_sent++;
        @(negedge clk);
        stream.valid = 1'b0;
    endtask

    task automatic write_count(input logic [23:0] n);
        cfg_wr_en = 1'b1;
        cfg_wr_data = n;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        vcount_m = n;
    endtask

    task automatic wait_drained();
        while (value_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic void push_field(input logic [63:0] val, input int unsigned n);
        for (int k = n - 1; k >= 0; k--)
            code_bits.push_back(val[k]);
    endfunction

    function automatic void push_code(input int f, input int sig_req);
        logic [2:0] c;
        int unsigned sig;
        case (f)
            0: begin
                push_field(xfsd_pkg::FLAG_COPY, 2);
                push_field($urandom, 7);
            end
            1: begin
                c = 3'($urandom);
                sig = (sig_req >= 0) ? sig_req : $urandom_range(63);
                push_field(xfsd_pkg::FLAG_REF_XOR, 2);
                push_field($urandom, 7);
                push_field(c, 3);
                push_field(sig, 6);
                push_field({$urandom, $urandom}, (sig == 0) ? 64 : sig);
                enc_lz = lz_code_m(c);
            end
            2: begin
                push_field(xfsd_pkg::FLAG_PREV, 2);
                push_field({$urandom, $urandom}, 64 - enc_lz);
            end
            default: begin
                c = 3'($urandom);
                enc_lz = lz_code_m(c);
                push_field(xfsd_pkg::FLAG_PREV_NEW_LZ, 2);
                push_field(c, 3);
                push_field({$urandom, $urandom}, 64 - enc_lz);
            end
        endcase
    endfunction

    function automatic void encode_block(input int unsigned n, input int f);
        code_bits.delete();
        enc_lz = 0;
        push_field({$urandom, $urandom}, 64);
        for (int unsigned k = 1; k < n; k++)
            push_code((f >= 0) ? f : $urandom_range(3), -1);
    endfunction

    task automatic send_bits(input int unsigned max_words);
        logic [63:0] w;
        int unsigned cnt;
        cnt = 0;
        while (code_bits.size() != 0 && cnt < max_words)
        begin
            for (int k = 63; k >= 0; k--)
                w[k] = (code_bits.size() != 0) ? code_bits.pop_front() : $urandom;
            send_word(w, cnt == 0);
            cnt++;
        end
        code_bits.delete();
    endtask

    task automatic test_reset_count();
        encode_block(12, -1);
        send_bits(100);
        wait_drained();
    endtask

    task automatic test_each_flag();
        write_count(24'd8);
        for (int f = 0; f < 4; f++)
        begin
            encode_block(8, f);
            send_bits(100);
        end
        wait_drained();
    endtask

    task automatic test_special_codes();
        write_count(24'd6);
        code_bits.delete();
        enc_lz = 0;
        push_field({$urandom, $urandom}, 64);
        push_code(1, 0);
        push_code(1, 63);
        push_field(xfsd_pkg::FLAG_REF_XOR, 2);
        push_field(7'd127, 7);
        push_field(3'd7, 3);
        push_field(6'd60, 6);
        push_field({$urandom, $urandom}, 60);
        enc_lz = 24;
        push_code(2, -1);
        push_code(0, -1);
        send_bits(100);
        send_word('1, 1'b0);
        send_word('0, 1'b1);
        send_word('1, 1'b0);
        send_word('1, 1'b1);
        wait_drained();
    endtask

    task automatic test_count_extremes();
        write_count(24'd1);
        encode_block(1, -1);
        send_bits(100);
        send_word({$urandom, $urandom}, 1'b1);
        wait_drained();
        write_count(24'hFFFFFF);
        encode_block(20, -1);
        send_bits(100);
        wait_drained();
        write_count(24'd1024);
        encode_block(10, -1);
        send_bits(100);
        wait_drained();
        write_count(24'd4);
        send_word({$urandom, $urandom}, 1'b0);
        wait_drained();
    endtask

    task automatic test_random(input int unsigned idle, input int unsigned stall,
                               input int unsigned words);
        int unsigned start_words;
        int unsigned n;
        int unsigned rem;
        src_idle = idle;
        snk_stall = stall;
        start_words = words_sent;
        while (words_sent - start_words < words)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
            write_count(24'(n));
            rem = words - (words_sent - start_words);
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_word({$urandom, $urandom}, 1'($urandom));
            end
            else
            begin
                encode_block(n, -1);
                send_bits(($urandom_range(7) == 0) ? $urandom_range(1, 5) : rem);
                if ($urandom_range(3) == 0)
                    send_word({$urandom, $urandom}, 1'b0);
            end
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        stream.valid = 1'b0;
        stream.stream_word = '0;
        stream.start_req = 1'b0;
        src_idle = 0;
        snk_stall = 0;
        words_sent = 0;
        values_seen = 0;
        errors = 0;
        vcount_m = xfsd_pkg::VALUE_COUNT_RESET;
        clear_m();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_count();
        test_each_flag();
        test_special_codes();
        test_count_extremes();
        test_random(0, 0, 66);
        test_random(64, 0, 66);
        test_random(0, 64, 66);
        test_random(35, 35, 66);
        wait_drained();
        $display("Covered %0d words and %0d decoded values over all flags, count limits",
                 words_sent, values_seen);
        $display("and four handshake pressure phases.");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
hw/rtl/xfsd_pkg.sv
hw/rtl/xfsd_if.sv
hw/rtl/xfsd_hist_mem.sv
hw/rtl/xor_float_stream_decoder_top.sv
tb/sv/tb_xor_float_stream_decoder_top.sv
